@@ rtl/wcel_pkg.sv @@
package wcel_pkg;

    localparam int NUM_CLASSES_DEF = 16;
    localparam int LABEL_W         = 8;
    localparam int VALUE_W         = 17;
    localparam int WEIGHT_W        = 16;
    localparam int LOSS_W          = 48;
    localparam int WTOT_W          = 40;
    localparam int NORM_W          = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd256;
    localparam logic [29:0]         LN2_Q30    = 30'd744261118;

    // Number of squaring rounds in the log unit and quotient bits in the divider
    localparam int LOG_STEPS = 30;
    localparam int DIV_STEPS = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_LBL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE = 2'd3;

    // Normalizer modes
    localparam logic [1:0] NORM_COUNT  = 2'd0;
    localparam logic [1:0] NORM_WEIGHT = 2'd1;
    localparam logic [1:0] NORM_BATCH  = 2'd2;
    localparam logic [1:0] NORM_NONE   = 2'd3;

    // Opcodes
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_ACC    = 1'b1;

    typedef struct packed {
        logic       load;
        logic       log_step;
        logic       mul_lo;
        logic       mul_hi;
        logic       round;
        logic       wmul;
        logic       acc;
        logic       norm;
        logic       div_step;
        logic       emit;
        logic [5:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic last;
    } stat_t;

endpackage

@@ rtl/wcel_if.sv @@
interface wcel_item_if;
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [wcel_pkg::LABEL_W-1:0]    class_label;
    logic [wcel_pkg::VALUE_W-1:0]    value;
    logic                            last;

    modport source (output valid, opcode, class_label, value, last, input ready);
    modport sink   (input valid, opcode, class_label, value, last, output ready);
endinterface

interface wcel_result_if;
    logic                            valid;
    logic                            ready;
    logic [wcel_pkg::LOSS_W-1:0]     loss;
    logic [wcel_pkg::WTOT_W-1:0]     weight_total;
    logic [wcel_pkg::NORM_W-1:0]     normalizer;
    logic                            bad_label;

    modport source (output valid, loss, weight_total, normalizer, bad_label, input ready);
    modport sink   (input valid, loss, weight_total, normalizer, bad_label, output ready);
endinterface

@@ rtl/wcel_ctrl.sv @@
module wcel_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  wcel_pkg::stat_t  stat,
    output wcel_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOG, S_MUL_LO, S_MUL_HI, S_ROUND, S_WMUL, S_ACC, S_NORM, S_DIV, S_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       rvalid_reg, rvalid_next;
    logic       accept;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = rvalid_reg;
    assign accept       = item_valid && item_ready;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rvalid_next = rvalid_reg && !result_ready;
        cmd         = '0;
        cmd.cnt     = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = S_LOG;
                end
            end
            S_LOG:
            begin
                // weight writes skip the log pipeline
                if (stat.op == wcel_pkg::OP_WEIGHT)
                begin
                    state_next = stat.last ? S_NORM : S_IDLE;
                end
                else
                begin
                    cmd.log_step = 1'b1;
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'(wcel_pkg::LOG_STEPS - 1))
                    begin
                        state_next = S_MUL_LO;
                    end
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                state_next = S_WMUL;
            end
            S_WMUL:
            begin
                cmd.wmul = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                state_next = stat.last ? S_NORM : S_IDLE;
            end
            S_NORM:
            begin
                cmd.norm = 1'b1;
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(wcel_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // wait until the output register is free
                if (!rvalid_reg || result_ready)
                begin
                    cmd.emit = 1'b1;
                    rvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= rvalid_next;
        end
    end

endmodule

@@ rtl/wcel_dp.sv @@
module wcel_dp
#(
    parameter int NUM_CLASSES = wcel_pkg::NUM_CLASSES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  wcel_pkg::cmd_t                     cmd,
    output wcel_pkg::stat_t                    stat,
    input  logic                               opcode,
    input  logic [wcel_pkg::LABEL_W-1:0]       class_label,
    input  logic [wcel_pkg::VALUE_W-1:0]       value,
    input  logic                               last,
    input  logic                               cfg_we,
    input  logic [wcel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wcel_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [wcel_pkg::LOSS_W-1:0]        loss,
    output logic [wcel_pkg::WTOT_W-1:0]        weight_total,
    output logic [wcel_pkg::NORM_W-1:0]        normalizer,
    output logic                               bad_label
);

    localparam int AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    // Configuration registers
    logic [1:0]  norm_mode_reg;
    logic        ign_en_reg;
    logic [7:0]  ign_lbl_reg;
    logic [15:0] batch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_mode_reg <= wcel_pkg::NORM_WEIGHT;
            ign_en_reg    <= 1'b0;
            ign_lbl_reg   <= 8'd255;
            batch_reg     <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wcel_pkg::REG_NORM_MODE:  norm_mode_reg <= cfg_data[1:0];
                wcel_pkg::REG_IGNORE_EN:  ign_en_reg    <= cfg_data[0];
                wcel_pkg::REG_IGNORE_LBL: ign_lbl_reg   <= cfg_data[7:0];
                wcel_pkg::REG_BATCH_SIZE: batch_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input decode
    logic          in_range, ignored, counted, big;
    logic [15:0]   p16;
    logic [3:0]    top_e;
    logic [AW-1:0] widx;

    assign in_range = ({1'b0, class_label} < 9'(NUM_CLASSES));
    assign ignored  = ign_en_reg && (class_label == ign_lbl_reg);
    assign counted  = (opcode == wcel_pkg::OP_ACC) && !ignored && in_range;
    assign big      = value[16];
    assign p16      = (value[15:0] == 16'd0) ? 16'd1 : value[15:0];
    assign widx     = class_label[AW-1:0];

    // Leading one of the probability
    always_comb
    begin
        top_e = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (p16[k])
            begin
                top_e = 4'(k);
            end
        end
    end

    // Class weight memory, valid bits stand for the reset value
    logic [wcel_pkg::WEIGHT_W-1:0] wmem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0]        wvalid_reg;
    logic [wcel_pkg::WEIGHT_W-1:0] w_reg;
    logic                          wr_en;

    assign wr_en = cmd.load && (opcode == wcel_pkg::OP_WEIGHT) && in_range;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wmem[widx] <= big ? 16'hFFFF : value[15:0];
        end
        if (cmd.load)
        begin
            w_reg <= wvalid_reg[widx] ? wmem[widx] : wcel_pkg::WEIGHT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
        end
        else if (wr_en)
        begin
            wvalid_reg[widx] <= 1'b1;
        end
    end

    // Item registers and log unit
    logic        op_reg, last_reg, counted_reg, big_reg;
    logic [30:0] x_reg;
    logic [34:0] l_reg;
    logic [61:0] sq;
    logic [31:0] sq_s;
    logic [34:0] nl2;
    logic [63:0] prod_reg;
    logic [46:0] hi_reg;
    logic [64:0] rsum;
    logic [19:0] nl_reg;
    logic [35:0] term_reg;

    assign sq   = 62'(x_reg) * 62'(x_reg);
    assign sq_s = sq[61:30];
    assign nl2  = (35'd16 << 30) - l_reg;
    assign rsum = 65'(prod_reg) + {hi_reg, 18'd0} + (65'd1 << 43);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= opcode;
            last_reg    <= last;
            counted_reg <= counted;
            big_reg     <= big;
            x_reg       <= 31'(p16) << (5'd30 - 5'(top_e));
            l_reg       <= {1'b0, top_e, 30'd0};
        end
        if (cmd.log_step)
        begin
            // square and renormalize, one fraction bit per round
            if (sq_s[31])
            begin
                x_reg <= sq_s[31:1];
                l_reg <= l_reg | (35'd1 << (5'd29 - cmd.cnt[4:0]));
            end
            else
            begin
                x_reg <= sq_s[30:0];
            end
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= 64'(nl2[17:0] * wcel_pkg::LN2_Q30);
        end
        if (cmd.mul_hi)
        begin
            hi_reg <= 47'(nl2[34:18] * wcel_pkg::LN2_Q30);
        end
        if (cmd.round)
        begin
            nl_reg <= big_reg ? 20'd0 : rsum[63:44];
        end
        if (cmd.wmul)
        begin
            term_reg <= 36'(nl_reg * w_reg);
        end
    end

    assign stat.op   = op_reg;
    assign stat.last = last_reg;

    // Accumulators
    logic [63:0] loss_sum_reg;
    logic [47:0] wsum_reg;
    logic [31:0] pcount_reg;
    logic        lerr_reg;
    logic [64:0] loss_add;
    logic [48:0] wsum_add;

    assign loss_add = 65'(loss_sum_reg) + 65'(term_reg);
    assign wsum_add = 49'(wsum_reg) + 49'(w_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_sum_reg <= '0;
            wsum_reg     <= '0;
            pcount_reg   <= '0;
            lerr_reg     <= 1'b0;
        end
        else if (cmd.norm)
        begin
            loss_sum_reg <= '0;
            wsum_reg     <= '0;
            pcount_reg   <= '0;
            lerr_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load && (opcode == wcel_pkg::OP_ACC))
            begin
                if (pcount_reg != 32'hFFFF_FFFF)
                begin
                    pcount_reg <= pcount_reg + 32'd1;
                end
                if (!ignored && !in_range)
                begin
                    lerr_reg <= 1'b1;
                end
            end
            if (cmd.acc && counted_reg)
            begin
                loss_sum_reg <= loss_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : loss_add[63:0];
                wsum_reg     <= wsum_add[48] ? 48'hFFFF_FFFF_FFFF : wsum_add[47:0];
            end
        end
    end

    // Normalizer select
    logic [31:0] norm_sel;
    logic [39:0] wint;

    assign wint = wsum_reg[47:8];

    always_comb
    begin
        case (norm_mode_reg)
            wcel_pkg::NORM_COUNT:  norm_sel = pcount_reg;
            wcel_pkg::NORM_WEIGHT: norm_sel = (wint[39:32] != 8'd0) ? 32'hFFFF_FFFF : wint[31:0];
            wcel_pkg::NORM_BATCH:  norm_sel = 32'(batch_reg);
            default:               norm_sel = 32'd1;
        endcase
        if (norm_sel == 32'd0)
        begin
            norm_sel = 32'd1;
        end
    end

    // Restoring divider, one quotient bit per cycle
    logic [31:0] norm_reg;
    logic [63:0] q_reg;
    logic [31:0] rem_reg;
    logic [39:0] wt_hold_reg;
    logic        bad_hold_reg;
    logic [32:0] r_sh;
    logic [32:0] r_sub;

    assign r_sh  = {rem_reg, q_reg[63]};
    assign r_sub = r_sh - {1'b0, norm_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.norm)
        begin
            norm_reg     <= norm_sel;
            q_reg        <= loss_sum_reg;
            rem_reg      <= '0;
            wt_hold_reg  <= (wsum_reg[47:40] != 8'd0) ? 40'hFF_FFFF_FFFF : wsum_reg[39:0];
            bad_hold_reg <= lerr_reg;
        end
        if (cmd.div_step)
        begin
            if (!r_sub[32])
            begin
                rem_reg <= r_sub[31:0];
                q_reg   <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= r_sh[31:0];
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
        // Output register
        if (cmd.emit)
        begin
            loss         <= (q_reg[63:48] != 16'd0) ? 48'hFFFF_FFFF_FFFF : q_reg[47:0];
            weight_total <= wt_hold_reg;
            normalizer   <= norm_reg;
            bad_label    <= bad_hold_reg;
        end
    end

endmodule

@@ rtl/weighted_cross_entropy_loss.sv @@
// A weight write is stored; a position runs log rounds, low/high products,
// round, weight multiply, accumulate; a last item adds normalizer select,
// 64-step divider, output load. One item at a time; the 30-round squaring log
// unit sets the per-position rate, the bit-serial divider the batch-end cost.
// Reset (rst_n, async, active low): class weights read as 1.0, sums clear,
// registers take norm_mode 1, ignore off, skipped label 255, batch_size 1.
module weighted_cross_entropy_loss
#(
    parameter int NUM_CLASSES = wcel_pkg::NUM_CLASSES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    wcel_item_if.sink                         item_ch,
    wcel_result_if.source                     result_ch,
    input  logic                              cfg_we,
    input  logic [wcel_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wcel_pkg::CFG_DATA_W-1:0]   cfg_data
);

    wcel_pkg::cmd_t  cmd;
    wcel_pkg::stat_t stat;

    wcel_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_ch.valid),
        .item_ready   (item_ch.ready),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    wcel_dp #(.NUM_CLASSES(NUM_CLASSES)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (item_ch.opcode),
        .class_label  (item_ch.class_label),
        .value        (item_ch.value),
        .last         (item_ch.last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .loss         (result_ch.loss),
        .weight_total (result_ch.weight_total),
        .normalizer   (result_ch.normalizer),
        .bad_label    (result_ch.bad_label)
    );

`ifndef ASSERT_OFF
    // An accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_ch.valid && item_ch.ready) |=> !item_ch.ready)
        else $error("input ready right after accept");

    // The divisor shown with a result is never zero
    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (result_ch.normalizer != 32'd0))
        else $error("zero normalizer on result");

    // A new result appears only when the block was not taking items
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_ch.valid) |-> $past(!item_ch.ready))
        else $error("result raised while idle");
`endif

endmodule

@@ test/wcel_loss_checker.sv @@
`timescale 1ns / 1ps

module wcel_loss_checker
(
    input  logic               clk,
    input  logic               rst_n,
    wcel_item_if               item_ch,
    wcel_result_if             result_ch,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending_losses
);
    import wcel_pkg::*;

    typedef struct packed {
        logic [LOSS_W-1:0] loss;
        logic [WTOT_W-1:0] weight_total;
        logic [NORM_W-1:0] normalizer;
        logic              bad_label;
    } loss_res_t;

    loss_res_t     loss_q[$];
    logic [15:0]   class_wt [NUM_CLASSES_DEF];
    logic [63:0]   loss_acc;
    logic [63:0]   wt_acc;
    logic [31:0]   pos_cnt;
    logic          lbl_err;
    logic [1:0]    mode_r;
    logic          ign_en_r;
    logic [7:0]    ign_lbl_r;
    logic [15:0]   batch_r;

    assign pending_losses = loss_q.size();

    // Negative natural log of a Q1.16 probability, Q.16 rounded
    function automatic logic [63:0] neg_ln_q16(logic [16:0] prob);
        logic [63:0] p;
        logic [63:0] x;
        logic [63:0] l;
        logic [63:0] prod;
        int          e;
        p = {47'd0, prob};
        if (p < 1) p = 1;
        if (p >= 65536) return 64'd0;
        e = 0;
        while (e < 15 && (p >> (e + 1)) != 0) e++;
        x = p << (30 - e);
        l = 64'(e) << 30;
        for (int i = 1; i <= 30; i++)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30))
            begin
                x = x >> 1;
                l = l | (64'd1 << (30 - i));
            end
        end
        prod = ((64'd16 << 30) - l) * 64'd744261118;
        return (prod + (64'd1 << 43)) >> 44;
    endfunction

    // Apply one accepted item; queue the batch result on last
    task automatic apply_item(logic op, logic [7:0] lbl, logic [16:0] val, logic lst);
        logic [63:0] w;
        logic [63:0] term;
        logic [63:0] norm;
        logic [63:0] q;
        loss_res_t   r;
        if (op == OP_WEIGHT)
        begin
            if (lbl < NUM_CLASSES_DEF)
                class_wt[lbl] = (val > 17'hFFFF) ? 16'hFFFF : val[15:0];
        end
        else
        begin
            if (pos_cnt != 32'hFFFF_FFFF) pos_cnt++;
            if (!(ign_en_r && lbl == ign_lbl_r))
            begin
                if (lbl >= NUM_CLASSES_DEF)
                    lbl_err = 1'b1;
                else
                begin
                    w = {48'd0, class_wt[lbl]};
                    term = neg_ln_q16(val) * w;
                    if (loss_acc > ~64'd0 - term) loss_acc = ~64'd0;
                    else loss_acc += term;
                    wt_acc += w;
                    if (wt_acc > 64'hFFFF_FFFF_FFFF) wt_acc = 64'hFFFF_FFFF_FFFF;
                end
            end
        end
        if (lst)
        begin
            case (mode_r)
                NORM_COUNT:  norm = {32'd0, pos_cnt};
                NORM_WEIGHT: norm = wt_acc >> 8;
                NORM_BATCH:  norm = {48'd0, batch_r};
                default:     norm = 64'd1;
            endcase
            if (norm < 1) norm = 1;
            if (norm > 64'hFFFF_FFFF) norm = 64'hFFFF_FFFF;
            q = loss_acc / norm;
            if (q > 64'hFFFF_FFFF_FFFF) q = 64'hFFFF_FFFF_FFFF;
            r.loss = q[47:0];
            r.weight_total = (wt_acc > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : wt_acc[39:0];
            r.normalizer = norm[31:0];
            r.bad_label = lbl_err;
            loss_q.insert(loss_q.size(), r);
            loss_acc = 0;
            wt_acc = 0;
            pos_cnt = 0;
            lbl_err = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        loss_res_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES_DEF; i++) class_wt[i] = 16'd256;
            loss_acc = 0;
            wt_acc = 0;
            pos_cnt = 0;
            lbl_err = 1'b0;
            mode_r = NORM_WEIGHT;
            ign_en_r = 1'b0;
            ign_lbl_r = 8'd255;
            batch_r = 16'd1;
            fail_count = 0;
            loss_q.delete();
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NORM_MODE:  mode_r = cfg_data[1:0];
                    REG_IGNORE_EN:  ign_en_r = cfg_data[0];
                    REG_IGNORE_LBL: ign_lbl_r = cfg_data[7:0];
                    REG_BATCH_SIZE: batch_r = cfg_data;
                    default: ;
                endcase
            end
            // compare results before new item (result can't come same edge as its item)
            if (result_ch.valid && result_ch.ready)
            begin
                if (loss_q.size() == 0)
                begin
                    $display("%0t: unexpected result loss=%h", $time, result_ch.loss);
                    fail_count++;
                end
                else
                begin
                    exp_r = loss_q.pop_front();
                    if (exp_r.loss !== result_ch.loss)
                    begin
                        $display("%0t: loss exp %h got %h", $time, exp_r.loss, result_ch.loss);
                        fail_count++;
                    end
                    if (exp_r.weight_total !== result_ch.weight_total)
                    begin
                        $display("%0t: weight_total exp %h got %h", $time,
                                 exp_r.weight_total, result_ch.weight_total);
                        fail_count++;
                    end
                    if (exp_r.normalizer !== result_ch.normalizer)
                    begin
                        $display("%0t: normalizer exp %h got %h", $time,
                                 exp_r.normalizer, result_ch.normalizer);
                        fail_count++;
                    end
                    if (exp_r.bad_label !== result_ch.bad_label)
                    begin
                        $display("%0t: bad_label exp %b got %b", $time,
                                 exp_r.bad_label, result_ch.bad_label);
                        fail_count++;
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
                apply_item(item_ch.opcode, item_ch.class_label, item_ch.value, item_ch.last);
        end
    end
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import wcel_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending_losses;
    int          gap_left;
    int          burst_left;
    int          stall_mode;

    wcel_item_if   item_ch ();
    wcel_result_if result_ch ();

    weighted_cross_entropy_loss u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wcel_loss_checker u_chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_ch        (item_ch),
        .result_ch      (result_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_losses (pending_losses)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Receiver stall pattern: phases of always-ready, random, and heavy stall
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       result_ch.ready <= 1'b1;
            1:       result_ch.ready <= ($urandom_range(0, 1) == 1);
            default: result_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stop sending, wait for all results, then cover the internal latency
    task automatic drain_block();
        item_ch.valid <= 1'b0;
        while (pending_losses != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    // Send one item, idling in bursts/gaps; valid held across back-to-back items.
    // The block is busy the cycle after an accept, so the stale item left on the
    // channel until the next falling edge is never taken twice.
    task automatic send_item(logic op, logic [7:0] lbl, logic [16:0] val, logic lst);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, 40);
            if (gap_left > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap_left) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.opcode <= op;
        item_ch.class_label <= lbl;
        item_ch.value <= val;
        item_ch.last <= lst;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [16:0] rand_prob();
        case ($urandom_range(0, 5))
            0:       return 17'($urandom_range(0, 3));
            1:       return 17'($urandom_range(65530, 131071));
            2:       return 17'($urandom_range(0, 131071));
            default: return 17'($urandom_range(1, 65536));
        endcase
    endfunction

    function automatic logic [7:0] rand_label();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, NUM_CLASSES_DEF - 1));
    endfunction

    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        int n_batches;
        int blen;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_NORM_MODE;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.opcode = OP_ACC;
        item_ch.class_label = '0;
        item_ch.value = '0;
        item_ch.last = 1'b0;
        result_ch.ready = 1'b1;
        stall_mode = 0;
        burst_left = 0;
        gap_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: defaults, clamps, extremes, ignore, out-of-range
        send_item(OP_ACC, 8'd0, 17'd0, 1'b0);
        send_item(OP_ACC, 8'd1, 17'd65536, 1'b0);
        send_item(OP_ACC, 8'd2, 17'h1FFFF, 1'b0);
        send_item(OP_ACC, 8'd3, 17'd1, 1'b0);
        send_item(OP_ACC, 8'd200, 17'd32768, 1'b1);
        send_item(OP_WEIGHT, 8'd15, 17'h1FFFF, 1'b0);
        send_item(OP_WEIGHT, 8'd0, 17'd0, 1'b0);
        send_item(OP_WEIGHT, 8'd255, 17'd1234, 1'b0);
        send_item(OP_ACC, 8'd15, 17'd1, 1'b0);
        send_item(OP_ACC, 8'd0, 17'd100, 1'b1);
        send_item(OP_WEIGHT, 8'd5, 17'd512, 1'b1);
        send_item(OP_ACC, 8'd255, 17'd7, 1'b1);
        drain_block();
        write_reg(REG_IGNORE_EN, 16'd1);
        write_reg(REG_IGNORE_LBL, 16'd255);
        write_reg(REG_NORM_MODE, 16'(NORM_COUNT));
        send_item(OP_ACC, 8'd255, 17'd5, 1'b0);
        send_item(OP_ACC, 8'd4, 17'd40000, 1'b1);
        drain_block();
        write_reg(REG_IGNORE_LBL, 16'd0);
        write_reg(REG_NORM_MODE, 16'(NORM_BATCH));
        write_reg(REG_BATCH_SIZE, 16'hFFFF);
        send_item(OP_ACC, 8'd0, 17'd5, 1'b0);
        send_item(OP_ACC, 8'd15, 17'd1, 1'b1);
        drain_block();
        write_reg(REG_NORM_MODE, 16'(NORM_NONE));
        write_reg(REG_BATCH_SIZE, 16'd0);
        send_item(OP_ACC, 8'd15, 17'd1, 1'b1);
        drain_block();

        // Random batches across settings
        n_batches = 0;
        for (int items = 0; items < 1000; )
        begin
            if (n_batches % 8 == 0)
            begin
                drain_block();
                write_reg(REG_NORM_MODE, 16'($urandom_range(0, 3)));
                write_reg(REG_IGNORE_EN, 16'($urandom_range(0, 1)));
                write_reg(REG_IGNORE_LBL, ($urandom_range(0, 1) == 1) ?
                          16'($urandom_range(0, NUM_CLASSES_DEF - 1)) : 16'($urandom_range(0, 255)));
                write_reg(REG_BATCH_SIZE, ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                          16'($urandom_range(1, 100)));
            end
            blen = $urandom_range(1, 30);
            for (int k = 0; k < blen; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(OP_WEIGHT, rand_label(), 17'($urandom_range(0, 131071)),
                              k == blen - 1);
                else
                    send_item(OP_ACC, rand_label(), rand_prob(), k == blen - 1);
                items++;
            end
            n_batches++;
        end

        drain_block();
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
